// File: rtl/text_mode_terminal_writer_core_assert.svh
// Assertion macros used by the terminal writer controller.
`ifndef TEXT_MODE_TERMINAL_WRITER_CORE_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk_i while out of reset.
`define TMTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i while out of reset.
`define TMTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tmtw_pkg.sv
// Shared types, constants and command/status structs of the terminal writer.
package tmtw_pkg;

  // Default screen geometry.
  localparam int DefColumns = 80;
  localparam int DefRows    = 25;
  localparam int DefTabStop = 4;

  // Fixed field widths.
  localparam int KindW   = 2;
  localparam int CharW   = 8;
  localparam int ColInW  = 7;
  localparam int RowInW  = 5;
  localparam int PosW    = 11;
  localparam int CellW   = 16;
  localparam int ColorW  = 4;
  localparam int CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFgColor = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBgColor = 1'd1;

  localparam logic [ColorW-1:0] FgReset = 4'd7;
  localparam logic [ColorW-1:0] BgReset = 4'd0;

  // Control characters.
  localparam logic [CharW-1:0] CharBackspace = 8'd8;
  localparam logic [CharW-1:0] CharTab       = 8'd9;
  localparam logic [CharW-1:0] CharNewline   = 8'd10;
  localparam logic [CharW-1:0] CharReturn    = 8'd13;
  localparam logic [CharW-1:0] CharSpace     = 8'd32;

  // Cell value after reset: space, light grey on black.
  localparam logic [CellW-1:0] CellReset = 16'h0720;

  typedef enum logic [KindW-1:0] {
    KindPut   = 2'd0,
    KindClear = 2'd1,
    KindSet   = 2'd2,
    KindRead  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    WrNone  = 3'd0,
    WrPut   = 3'd1,
    WrCopy  = 3'd2,
    WrBlank = 3'd3,
    WrInit  = 3'd4
  } wr_mode_e;

  typedef struct packed {
    logic     load_item;
    logic     exec_put;
    logic     exec_set;
    logic     cursor_home;
    logic     rd_item;
    logic     rd_sweep;
    logic     rd_ahead;
    wr_mode_e wr_mode;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     out_load;
    logic     out_cell;
    logic     out_scrolled;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scroll_req;
    logic  out_busy;
    logic  copy_end;
    logic  cnt_end;
  } sts_t;

endpackage

// File: rtl/tmtw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmtw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tmtw_dp.sv
// Datapath: item and cursor registers, address generation, text store, result register.
module tmtw_dp #(
  parameter int COLUMNS  = tmtw_pkg::DefColumns,
  parameter int ROWS     = tmtw_pkg::DefRows,
  parameter int TAB_STOP = tmtw_pkg::DefTabStop
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tmtw_pkg::KindW-1:0]   kind_i,
  input  logic [tmtw_pkg::CharW-1:0]   char_code_i,
  input  logic [tmtw_pkg::ColInW-1:0]  col_i,
  input  logic [tmtw_pkg::RowInW-1:0]  row_i,
  input  logic                         cfg_we_i,
  input  logic [tmtw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmtw_pkg::ColorW-1:0]  cfg_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [tmtw_pkg::PosW-1:0]    cursor_pos_o,
  output logic [tmtw_pkg::CellW-1:0]   cell_data_o,
  output logic                         scrolled_o,
  input  tmtw_pkg::cmd_t               cmd_i,
  output tmtw_pkg::sts_t               sts_o
);

  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(ROWS);
  localparam int Cells = COLUMNS * ROWS;
  localparam int AddrW = $clog2(Cells);

  // Latched item.
  logic [tmtw_pkg::KindW-1:0]  kind_q;
  logic [tmtw_pkg::CharW-1:0]  char_q;
  logic [tmtw_pkg::ColInW-1:0] col_in_q;
  logic [tmtw_pkg::RowInW-1:0] row_in_q;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [tmtw_pkg::ColorW-1:0] fg_q, bg_q;
  logic [AddrW-1:0] cnt_q, cnt_d;

  logic                        out_valid_q, out_valid_d;
  logic [tmtw_pkg::PosW-1:0]   pos_q;
  logic [tmtw_pkg::CellW-1:0]  cell_q;
  logic                        scrolled_q;

  // Next tab stop for every column, worked out at elaboration.
  logic [ColW-1:0] tab_col  [COLUMNS];
  logic            tab_wrap [COLUMNS];

  for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
    localparam int Nxt = (g / TAB_STOP + 1) * TAB_STOP;
    assign tab_col[g]  = (Nxt >= COLUMNS) ? '0 : ColW'(Nxt);
    assign tab_wrap[g] = (Nxt >= COLUMNS);
  end

  logic [ColW-1:0]            put_col, put_wcol;
  logic                       put_adv, put_we;
  logic [tmtw_pkg::CharW-1:0] put_byte;
  logic [tmtw_pkg::CharW-1:0] attr;
  logic                       row_last;
  logic [ColW-1:0]            clamp_col;
  logic [RowW-1:0]            clamp_row;
  logic [AddrW-1:0]           put_addr, item_addr, sweep_addr;

  logic                       ram_we, ram_re;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [tmtw_pkg::CellW-1:0] ram_wdata, ram_rdata;

  assign attr     = {bg_q, fg_q};
  assign row_last = (row_q == RowW'(ROWS - 1));

  // Put-character decode against the current cursor.
  always_comb begin
    put_col  = col_q;
    put_wcol = col_q;
    put_adv  = 1'b0;
    put_we   = 1'b0;
    put_byte = char_q;
    case (char_q)
      tmtw_pkg::CharNewline: begin
        put_col = '0;
        put_adv = 1'b1;
      end
      tmtw_pkg::CharReturn: begin
        put_col = '0;
      end
      tmtw_pkg::CharBackspace: begin
        put_byte = tmtw_pkg::CharSpace;
        if (col_q != '0) begin
          put_col  = col_q - 1'b1;
          put_wcol = col_q - 1'b1;
          put_we   = 1'b1;
        end
      end
      tmtw_pkg::CharTab: begin
        put_col = tab_col[col_q];
        put_adv = tab_wrap[col_q];
      end
      default: begin
        put_we = 1'b1;
        if (col_q == ColW'(COLUMNS - 1)) begin
          put_col = '0;
          put_adv = 1'b1;
        end else begin
          put_col = col_q + 1'b1;
        end
      end
    endcase
  end

  assign clamp_col = (32'(col_in_q) >= COLUMNS) ? ColW'(COLUMNS - 1) : ColW'(col_in_q);
  assign clamp_row = (32'(row_in_q) >= ROWS) ? RowW'(ROWS - 1) : RowW'(row_in_q);

  assign put_addr   = AddrW'(32'(row_q) * COLUMNS + 32'(put_wcol));
  assign item_addr  = AddrW'(32'(clamp_row) * COLUMNS + 32'(clamp_col));
  assign sweep_addr = AddrW'(32'(cnt_q) + COLUMNS + 32'(cmd_i.rd_ahead));

  // Cursor update.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.exec_put) begin
      col_d = put_col;
      if (put_adv && !row_last) begin
        row_d = row_q + 1'b1;
      end
    end
    if (cmd_i.exec_set) begin
      col_d = clamp_col;
      row_d = clamp_row;
    end
    if (cmd_i.cursor_home) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // Store write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = tmtw_pkg::CellReset;
    case (cmd_i.wr_mode)
      tmtw_pkg::WrPut: begin
        ram_we    = put_we;
        ram_waddr = put_addr;
        ram_wdata = {attr, put_byte};
      end
      tmtw_pkg::WrCopy: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      tmtw_pkg::WrBlank: begin
        ram_we    = 1'b1;
        ram_wdata = {attr, tmtw_pkg::CharSpace};
      end
      tmtw_pkg::WrInit: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_re    = cmd_i.rd_item | cmd_i.rd_sweep;
  assign ram_raddr = cmd_i.rd_item ? item_addr : sweep_addr;

  tmtw_ram #(
    .Width (tmtw_pkg::CellW),
    .Depth (Cells)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      fg_q        <= tmtw_pkg::FgReset;
      bg_q        <= tmtw_pkg::BgReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == tmtw_pkg::CfgFgColor) begin
        fg_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == tmtw_pkg::CfgBgColor) begin
        bg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q   <= kind_i;
      char_q   <= char_code_i;
      col_in_q <= col_i;
      row_in_q <= row_i;
    end
    if (cmd_i.out_load) begin
      pos_q      <= tmtw_pkg::PosW'(32'(row_d) * COLUMNS + 32'(col_d));
      cell_q     <= cmd_i.out_cell ? ram_rdata : '0;
      scrolled_q <= cmd_i.out_scrolled;
    end
  end

  assign sts_o.kind       = tmtw_pkg::kind_e'(kind_q);
  assign sts_o.scroll_req = put_adv & row_last;
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;
  assign sts_o.copy_end   = (cnt_q == AddrW'(Cells - COLUMNS - 1));
  assign sts_o.cnt_end    = (cnt_q == AddrW'(Cells - 1));

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign cell_data_o  = cell_q;
  assign scrolled_o   = scrolled_q;

endmodule

// File: rtl/tmtw_ctrl.sv
// Controller: sequences item execution, store sweeps and the result beat.
`include "text_mode_terminal_writer_core_assert.svh"

module tmtw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tmtw_pkg::sts_t sts_i,
  output tmtw_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StExec,
    StRead,
    StScPre,
    StScCopy,
    StScBlank,
    StClear,
    StFin
  } state_e;

  state_e state_q, state_d;
  logic   fin_scrolled_q, fin_scrolled_d;
  tmtw_pkg::cmd_t cmd;

  always_comb begin
    state_d        = state_q;
    fin_scrolled_d = fin_scrolled_q;
    cmd            = '0;
    case (state_q)
      StInit: begin
        cmd.wr_mode = tmtw_pkg::WrInit;
        cmd.cnt_inc = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        // Hold the item until the result register can take its beat.
        if (!sts_i.out_busy) begin
          case (sts_i.kind)
            tmtw_pkg::KindPut: begin
              cmd.exec_put = 1'b1;
              cmd.wr_mode  = tmtw_pkg::WrPut;
              cmd.cnt_clr  = 1'b1;
              if (sts_i.scroll_req) begin
                fin_scrolled_d = 1'b1;
                state_d        = StScPre;
              end else begin
                cmd.out_load = 1'b1;
                state_d      = StIdle;
              end
            end
            tmtw_pkg::KindClear: begin
              cmd.cursor_home = 1'b1;
              cmd.cnt_clr     = 1'b1;
              fin_scrolled_d  = 1'b0;
              state_d         = StClear;
            end
            tmtw_pkg::KindSet: begin
              cmd.exec_set = 1'b1;
              cmd.out_load = 1'b1;
              state_d      = StIdle;
            end
            default: begin
              cmd.rd_item = 1'b1;
              state_d     = StRead;
            end
          endcase
        end
      end
      StRead: begin
        if (!sts_i.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_cell = 1'b1;
          state_d      = StIdle;
        end
      end
      StScPre: begin
        cmd.rd_sweep = 1'b1;
        state_d      = StScCopy;
      end
      StScCopy: begin
        // Write the row below into the current cell, fetch the next one.
        cmd.wr_mode = tmtw_pkg::WrCopy;
        cmd.cnt_inc = 1'b1;
        if (sts_i.copy_end) begin
          state_d = StScBlank;
        end else begin
          cmd.rd_sweep = 1'b1;
          cmd.rd_ahead = 1'b1;
        end
      end
      StScBlank, StClear: begin
        cmd.wr_mode = tmtw_pkg::WrBlank;
        cmd.cnt_inc = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!sts_i.out_busy) begin
          cmd.out_load     = 1'b1;
          cmd.out_scrolled = fin_scrolled_q;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StInit;
      fin_scrolled_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      fin_scrolled_q <= fin_scrolled_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign cmd_o      = cmd;

  `TMTW_ASSERT_IMP(a_load_free, cmd.out_load, !sts_i.out_busy, "result loaded while busy")
  `TMTW_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second beat taken")
  `TMTW_ASSERT_IMP(a_copy_fed, cmd.wr_mode == tmtw_pkg::WrCopy, $past(cmd.rd_sweep), "copy w/o read")

endmodule

// File: rtl/text_mode_terminal_writer_core.sv
// Top level of the text terminal writer: controller plus datapath.
//
// Input beats (in_valid_i/in_ready_o) carry kind_i, char_code_i, col_i and
// row_i; every beat yields one result beat (out_valid_o/out_ready_i) with
// the linear cursor position, the cell read (read kind only) and a scroll
// flag. One item is worked on at a time, and the next one is taken while
// the previous result still waits in the output register.
// Put-character without scroll and set-cursor load the result straight from
// the execute state; read-cell passes a registered store read first.
// Clear and a scrolling put sweep all COLUMNS*ROWS cells, bound by the one
// write and one read port of the text store.
// After reset a clearing pass writes 0x0720 into all COLUMNS*ROWS cells, one
// a cycle; in_ready_o stays low until it is done.
// Color registers are written through cfg_we_i/cfg_idx_i/cfg_data_i at any
// edge, and should be changed only between items.
// A stalled receiver holds the result; the block then stops before it
// executes the next item, so nothing is lost or reordered.
module text_mode_terminal_writer_core #(
  parameter int COLUMNS  = tmtw_pkg::DefColumns,
  parameter int ROWS     = tmtw_pkg::DefRows,
  parameter int TAB_STOP = tmtw_pkg::DefTabStop
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tmtw_pkg::KindW-1:0]   kind_i,
  input  logic [tmtw_pkg::CharW-1:0]   char_code_i,
  input  logic [tmtw_pkg::ColInW-1:0]  col_i,
  input  logic [tmtw_pkg::RowInW-1:0]  row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tmtw_pkg::PosW-1:0]    cursor_pos_o,
  output logic [tmtw_pkg::CellW-1:0]   cell_data_o,
  output logic                         scrolled_o,
  input  logic                         cfg_we_i,
  input  logic [tmtw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmtw_pkg::ColorW-1:0]  cfg_data_i
);

  tmtw_pkg::cmd_t cmd;
  tmtw_pkg::sts_t sts;

  tmtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmtw_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .cursor_pos_o (cursor_pos_o),
    .cell_data_o  (cell_data_o),
    .scrolled_o   (scrolled_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// File: dv/text_mode_terminal_writer_checker.sv
`timescale 1ns / 1ps
// Checker for the terminal writer: mirrors the screen, cursor and colors and compares result beats.
module text_mode_terminal_writer_checker #(
  parameter int COLUMNS  = tmtw_pkg::DefColumns,
  parameter int ROWS     = tmtw_pkg::DefRows,
  parameter int TAB_STOP = tmtw_pkg::DefTabStop
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [tmtw_pkg::KindW-1:0]   kind_i,
  input  logic [tmtw_pkg::CharW-1:0]   char_code_i,
  input  logic [tmtw_pkg::ColInW-1:0]  col_i,
  input  logic [tmtw_pkg::RowInW-1:0]  row_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [tmtw_pkg::PosW-1:0]    cursor_pos_i,
  input  logic [tmtw_pkg::CellW-1:0]   cell_data_i,
  input  logic                         scrolled_i,
  input  logic                         cfg_we_i,
  input  logic [tmtw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmtw_pkg::ColorW-1:0]  cfg_data_i,
  output int                           fail_count_o
);
  import tmtw_pkg::*;

  localparam int Cells = COLUMNS * ROWS;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [CellW-1:0] cell_word;
    logic             scrolled;
  } term_report_t;

  logic [CellW-1:0]  screen_cells [Cells];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ColorW-1:0] fg_color;
  logic [ColorW-1:0] bg_color;
  term_report_t      pending_reports [$];
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // The attribute byte is the background nibble over the foreground nibble.
  function automatic logic [CellW-1:0] make_cell(input logic [CharW-1:0] ch);
    return {bg_color, fg_color, ch};
  endfunction

  task automatic next_line();
    cur_col = 0;
    cur_row++;
  endtask

  task automatic apply_terminal_item(input kind_e kind, input logic [CharW-1:0] ch,
                                     input logic [ColInW-1:0] col,
                                     input logic [RowInW-1:0] row);
    term_report_t rep;
    int unsigned  c;
    int unsigned  r;
    rep = '0;
    case (kind)
      KindPut: begin
        if (ch == CharNewline) begin
          next_line();
        end else if (ch == CharReturn) begin
          cur_col = 0;
        end else if (ch == CharBackspace) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_cells[cur_row * COLUMNS + cur_col] = make_cell(CharSpace);
          end
        end else if (ch == CharTab) begin
          cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
          if (cur_col >= COLUMNS) next_line();
        end else begin
          screen_cells[cur_row * COLUMNS + cur_col] = make_cell(ch);
          cur_col++;
          if (cur_col >= COLUMNS) next_line();
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < Cells - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
          for (int i = Cells - COLUMNS; i < Cells; i++) screen_cells[i] = make_cell(CharSpace);
          cur_row = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      KindClear: begin
        for (int i = 0; i < Cells; i++) screen_cells[i] = make_cell(CharSpace);
        cur_col = 0;
        cur_row = 0;
      end
      KindSet: begin
        cur_col = (32'(col) >= COLUMNS) ? COLUMNS - 1 : 32'(col);
        cur_row = (32'(row) >= ROWS) ? ROWS - 1 : 32'(row);
      end
      default: begin
        c = (32'(col) >= COLUMNS) ? COLUMNS - 1 : 32'(col);
        r = (32'(row) >= ROWS) ? ROWS - 1 : 32'(row);
        rep.cell_word = screen_cells[r * COLUMNS + c];
      end
    endcase
    rep.pos = PosW'(cur_row * COLUMNS + cur_col);
    pending_reports.push_back(rep);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    term_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Cells; i++) screen_cells[i] = CellReset;
      cur_col  = 0;
      cur_row  = 0;
      fg_color = FgReset;
      bg_color = BgReset;
      pending_reports.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("result beat with nothing pending", 32'(cursor_pos_i), 32'(0));
        end else begin
          want = pending_reports.pop_front();
          if (cursor_pos_i !== want.pos) begin
            report_mismatch("cursor_pos", 32'(cursor_pos_i), 32'(want.pos));
          end
          if (cell_data_i !== want.cell_word) begin
            report_mismatch("cell_data", 32'(cell_data_i), 32'(want.cell_word));
          end
          if (scrolled_i !== want.scrolled) begin
            report_mismatch("scrolled", 32'(scrolled_i), 32'(want.scrolled));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgFgColor) begin
          fg_color = cfg_data_i;
        end else if (cfg_idx_i == CfgBgColor) begin
          bg_color = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_terminal_item(kind_e'(kind_i), char_code_i, col_i, row_i);
      end
    end
  end

endmodule

// File: dv/text_mode_terminal_writer_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the terminal writer: directed and random items with random idling.
module text_mode_terminal_writer_core_tb;
  import tmtw_pkg::*;

  localparam int          MaxIdle        = 18;
  localparam int          RandomPhases   = 5;
  localparam int          RandomPerPhase = 230;
  localparam int          DrainCycles    = 10;
  localparam int unsigned Cells          = DefColumns * DefRows;
  localparam int unsigned ItemBound      = 1300;
  // Every item as a scrolling put with both sides at their longest idle, three times over.
  localparam int unsigned CycleLimit =
    3 * (Cells + ItemBound * (Cells + 3 + 2 * (MaxIdle + 1)));

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KindW-1:0]   kind = KindPut;
  logic [CharW-1:0]   char_code = '0;
  logic [ColInW-1:0]  col = '0;
  logic [RowInW-1:0]  row = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PosW-1:0]    cursor_pos;
  logic [CellW-1:0]   cell_data;
  logic               scrolled;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CfgFgColor;
  logic [ColorW-1:0]  cfg_data = '0;
  int                 fail_count;
  int unsigned        items_sent = 0;
  int unsigned        results_seen = 0;
  int unsigned        cycle_count = 0;
  bit                 in_quiet = 1'b0;
  bit                 out_quiet = 1'b0;

  text_mode_terminal_writer_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .char_code_i (char_code),
    .col_i       (col),
    .row_i       (row),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .cursor_pos_o(cursor_pos),
    .cell_data_o (cell_data),
    .scrolled_o  (scrolled),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  text_mode_terminal_writer_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .kind_i      (kind),
    .char_code_i (char_code),
    .col_i       (col),
    .row_i       (row),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .cursor_pos_i(cursor_pos),
    .cell_data_i (cell_data),
    .scrolled_i  (scrolled),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: stalls a random number of cycles before each result beat, with quiet stretches.
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  task automatic send_item(input kind_e k, input logic [CharW-1:0] ch,
                           input logic [ColInW-1:0] c, input logic [RowInW-1:0] r);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= ch;
    col       <= c;
    row       <= r;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Mostly character puts of random bytes with control characters mixed in; the cursor is moved often,
  // frequently near the right edge or onto the bottom row so wraps and scrolls happen.
  task automatic send_random_item();
    int unsigned       pick;
    kind_e             k;
    logic [CharW-1:0]  ch;
    logic [ColInW-1:0] c;
    logic [RowInW-1:0] r;
    pick = $urandom_range(0, 999);
    ch   = CharW'($urandom_range(0, 255));
    c    = ColInW'($urandom_range(0, 127));
    r    = RowInW'($urandom_range(0, 31));
    if (pick < 10) begin
      k = KindClear;
    end else if (pick < 130) begin
      k = KindSet;
      if ($urandom_range(0, 1) == 1) c = ColInW'($urandom_range(DefColumns - 8, DefColumns - 1));
    end else if (pick < 250) begin
      k = KindRead;
    end else begin
      k = KindPut;
      case ($urandom_range(0, 9))
        0: ch = CharNewline;
        1: ch = CharTab;
        2: ch = CharBackspace;
        3: ch = CharReturn;
        default: ;
      endcase
    end
    send_item(k, ch, c, r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic write_colors(input logic [ColorW-1:0] fg, input logic [ColorW-1:0] bg);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgFgColor;
    cfg_data <= fg;
    @(posedge clk);
    cfg_idx  <= CfgBgColor;
    cfg_data <= bg;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_colors(4'hC, 4'h1);

    send_item(KindRead, 8'h00, 7'd0, 5'd0);
    send_item(KindRead, 8'hFF, 7'd127, 5'd31);
    send_item(KindPut, 8'h41, 7'd0, 5'd0);
    send_item(KindPut, 8'hFF, 7'd127, 5'd31);
    send_item(KindPut, 8'h80, 7'd0, 5'd0);
    send_item(KindPut, 8'h00, 7'd0, 5'd0);
    send_item(KindPut, CharBackspace, 7'd0, 5'd0);
    send_item(KindRead, 8'h00, 7'd3, 5'd0);
    send_item(KindRead, 8'h00, 7'd1, 5'd0);
    send_item(KindPut, CharTab, 7'd0, 5'd0);
    send_item(KindPut, CharTab, 7'd0, 5'd0);
    send_item(KindPut, CharReturn, 7'd0, 5'd0);
    send_item(KindPut, CharBackspace, 7'd0, 5'd0);
    // Clamped to the bottom right corner; the next character wraps and scrolls.
    send_item(KindSet, 8'h00, 7'd127, 5'd31);
    send_item(KindPut, 8'h7E, 7'd0, 5'd0);
    send_item(KindRead, 8'h00, 7'd79, 5'd23);
    send_item(KindPut, CharNewline, 7'd0, 5'd0);
    send_item(KindSet, 8'h00, 7'd77, 5'd24);
    send_item(KindPut, CharTab, 7'd0, 5'd0);
    send_item(KindSet, 8'h00, 7'd76, 5'd5);
    send_item(KindPut, CharTab, 7'd0, 5'd0);
    send_item(KindRead, 8'h00, 7'd0, 5'd24);
    send_item(KindClear, 8'h00, 7'd0, 5'd0);
    send_item(KindRead, 8'h00, 7'd50, 5'd20);
    send_item(KindPut, 8'h7F, 7'd0, 5'd0);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      case (phase)
        0: write_colors(4'hF, 4'hF);
        1: write_colors(4'h0, 4'h0);
        2: write_colors(FgReset, BgReset);
        3: write_colors(4'h0, 4'hF);
        default: write_colors(ColorW'($urandom_range(0, 15)), ColorW'($urandom_range(0, 15)));
      endcase
      repeat (RandomPerPhase) send_random_item();
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
